// ----- rtl/core/timestamp_ordered_frame_queue_assert.svh -----
// Assertion macros for the frame queue
`ifndef TIMESTAMP_ORDERED_FRAME_QUEUE_ASSERT_SVH
`define TIMESTAMP_ORDERED_FRAME_QUEUE_ASSERT_SVH

// Same-cycle implication
`define TOFQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TOFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tofq_pkg.sv -----
package tofq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Input beat, first field in the highest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] frame_tag;
    logic [23:0] data_len;
    logic        key_frame;
    logic        track_type;
    logic        is_cluster;
    logic [63:0] timestamp_ms;
    logic [1:0]  command;
  } in_t;

  // Output beat, first field in the highest bits
  typedef struct packed {
    logic        audio_pending;
    logic        video_pending;
    logic        queue_empty;
    logic [23:0] out_data_len;
    logic        out_key_frame;
    logic        out_track;
    logic        out_is_cluster;
    logic [15:0] delta_ms;
    logic [63:0] out_timestamp_ms;
    logic [15:0] out_tag;
    logic [1:0]  status;
  } out_t;

  // One queue entry in memory
  typedef struct packed {
    logic [63:0] ts;
    logic [15:0] delta;
    logic        key;
    logic        track;
    logic        cluster;
    logic [23:0] len;
    logic [15:0] tag;
  } entry_t;

endpackage

// ----- rtl/core/timestamp_ordered_frame_queue.sv -----
// Add scans the pending frames up to the insertion point, shifts the queued frames behind it
// up by one entry and writes the new frame; when a cluster goes ahead of queued frames, the
// delta rewrite walk over the queue follows. Pop and peek take one memory read.
// One beat is in work at a time; the next is taken once the result beat is delivered.
// rst_ni clears the count, head pointer and cluster base; entry memory is not cleared.
module timestamp_ordered_frame_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // command, timestamp_ms, is_cluster, track_type, key_frame, data_len, frame_tag, pad
  input  logic [111:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status, out_tag, out_timestamp_ms, delta_ms, out_is_cluster, out_track,
  // out_key_frame, out_data_len, queue_empty, video_pending, audio_pending
  output logic [127:0] m_axis_tdata_o
);

  `include "timestamp_ordered_frame_queue_assert.svh"

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SEV  = 4'd2;
  localparam logic [3:0] S_HRD  = 4'd3;
  localparam logic [3:0] S_HEV  = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_REV  = 4'd7;
  localparam logic [3:0] S_POP  = 4'd8;

  localparam logic [tofq_pkg::CntW-1:0] FullCnt = tofq_pkg::CntW'(tofq_pkg::QueueDepth);
  localparam logic [tofq_pkg::CntW-1:0] CntOne = tofq_pkg::CntW'(1);
  localparam logic [tofq_pkg::AddrW-1:0] AddrOne = tofq_pkg::AddrW'(1);

  tofq_pkg::entry_t mem [tofq_pkg::QueueDepth];
  tofq_pkg::entry_t rd_q, wd;
  logic [tofq_pkg::AddrW-1:0] rd_addr, wa;
  logic we;

  logic [3:0] state_q;
  tofq_pkg::in_t in_d, in_q;
  logic [tofq_pkg::CntW-1:0] idx_q, pos_q, count_q, aud_q;
  logic [tofq_pkg::AddrW-1:0] head_q;
  logic [63:0] base_q, cbase_q;
  logic fix_q, started_q;
  logic out_vld_q;
  tofq_pkg::out_t res_q, res_d, out_beat;
  logic accept;
  logic later;
  logic [63:0] rbase;
  logic rstart;

  assign in_d = tofq_pkg::in_t'(s_axis_tdata_i);
  assign s_axis_tready_o = (state_q == S_IDLE) && !out_vld_q;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Entry memory: one read, one write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  // Compare the new frame against the entry just read
  assign later = (in_q.timestamp_ms < rd_q.ts) ||
                 ((in_q.timestamp_ms == rd_q.ts) && !in_q.track_type);
  assign rstart = started_q || rd_q.cluster;
  assign rbase = rd_q.cluster ? rd_q.ts : base_q;

  // Drive memory address and write data per state
  always_comb begin
    rd_addr = head_q;
    wa = head_q;
    we = 1'b0;
    wd = rd_q;
    case (state_q)
      S_SRD, S_RRD: rd_addr = head_q + idx_q[tofq_pkg::AddrW-1:0];
      S_HRD: rd_addr = head_q + idx_q[tofq_pkg::AddrW-1:0] - AddrOne;
      S_HEV: begin
        we = 1'b1;
        wa = head_q + idx_q[tofq_pkg::AddrW-1:0];
      end
      S_WR: begin
        we = 1'b1;
        wa = head_q + pos_q[tofq_pkg::AddrW-1:0];
        wd.ts = in_q.timestamp_ms;
        wd.delta = in_q.is_cluster ? 16'd0 : (in_q.timestamp_ms[15:0] - base_q[15:0]);
        wd.key = in_q.key_frame;
        wd.track = in_q.track_type;
        wd.cluster = in_q.is_cluster;
        wd.len = in_q.data_len;
        wd.tag = in_q.frame_tag;
      end
      S_REV: begin
        we = rstart;
        wa = head_q + idx_q[tofq_pkg::AddrW-1:0];
        wd.delta = rd_q.ts[15:0] - rbase[15:0];
      end
      default: ;
    endcase
  end

  // Build the result beat loaded in the current state
  always_comb begin
    res_d = '0;
    case (state_q)
      S_IDLE: begin
        if (in_d.command == tofq_pkg::CMD_ADD) begin
          if (count_q == FullCnt) begin
            res_d.status = tofq_pkg::ST_FULL;
            res_d.out_tag = in_d.frame_tag;
            res_d.out_timestamp_ms = in_d.timestamp_ms;
            res_d.out_is_cluster = in_d.is_cluster;
            res_d.out_track = in_d.track_type;
            res_d.out_key_frame = in_d.key_frame;
            res_d.out_data_len = in_d.data_len;
          end
        end else if (in_d.command == tofq_pkg::CMD_POP ||
                     in_d.command == tofq_pkg::CMD_PEEK) begin
          if (count_q == '0) begin
            res_d.status = tofq_pkg::ST_EMPTY;
          end
        end
      end
      S_WR: begin
        res_d.status = tofq_pkg::ST_OK;
        res_d.out_tag = in_q.frame_tag;
        res_d.out_timestamp_ms = in_q.timestamp_ms;
        res_d.delta_ms = wd.delta;
        res_d.out_is_cluster = in_q.is_cluster;
        res_d.out_track = in_q.track_type;
        res_d.out_key_frame = in_q.key_frame;
        res_d.out_data_len = in_q.data_len;
      end
      S_POP: begin
        res_d.status = tofq_pkg::ST_OK;
        res_d.out_tag = rd_q.tag;
        res_d.out_timestamp_ms = rd_q.ts;
        res_d.delta_ms = rd_q.delta;
        res_d.out_is_cluster = rd_q.cluster;
        res_d.out_track = rd_q.track;
        res_d.out_key_frame = rd_q.key;
        res_d.out_data_len = rd_q.len;
      end
      default: ;
    endcase
  end

  // Sequencer: scan, shift, write, rewrite deltas, pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      aud_q <= '0;
      head_q <= '0;
      cbase_q <= '0;
      out_vld_q <= 1'b0;
      in_q <= '0;
      res_q <= '0;
      idx_q <= '0;
      pos_q <= '0;
      base_q <= '0;
      fix_q <= 1'b0;
      started_q <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            in_q <= in_d;
            res_q <= res_d;
            case (in_d.command)
              tofq_pkg::CMD_ADD: begin
                if (count_q == FullCnt) begin
                  out_vld_q <= 1'b1;
                end else begin
                  idx_q <= '0;
                  base_q <= cbase_q;
                  fix_q <= 1'b0;
                  state_q <= S_SRD;
                end
              end
              tofq_pkg::CMD_POP, tofq_pkg::CMD_PEEK: begin
                if (count_q == '0) begin
                  out_vld_q <= 1'b1;
                end else begin
                  state_q <= S_POP;
                end
              end
              default: out_vld_q <= 1'b1;
            endcase
          end
        end
        S_SRD: begin
          if (idx_q == count_q) begin
            pos_q <= count_q;
            state_q <= S_WR;
          end else begin
            state_q <= S_SEV;
          end
        end
        S_SEV: begin
          if (later) begin
            pos_q <= idx_q;
            fix_q <= in_q.is_cluster;
            idx_q <= count_q;
            state_q <= S_HRD;
          end else begin
            if (rd_q.cluster) begin
              base_q <= rd_q.ts;
            end
            idx_q <= idx_q + CntOne;
            state_q <= S_SRD;
          end
        end
        S_HRD: state_q <= (idx_q == pos_q) ? S_WR : S_HEV;
        S_HEV: begin
          idx_q <= idx_q - CntOne;
          state_q <= S_HRD;
        end
        S_WR: begin
          count_q <= count_q + CntOne;
          aud_q <= aud_q + tofq_pkg::CntW'(in_q.track_type);
          res_q <= res_d;
          if (fix_q) begin
            idx_q <= '0;
            started_q <= 1'b0;
            base_q <= '0;
            state_q <= S_RRD;
          end else begin
            out_vld_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_RRD: begin
          if (idx_q == count_q) begin
            out_vld_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_REV;
          end
        end
        S_REV: begin
          started_q <= rstart;
          base_q <= rbase;
          idx_q <= idx_q + CntOne;
          state_q <= S_RRD;
        end
        S_POP: begin
          res_q <= res_d;
          if (in_q.command == tofq_pkg::CMD_POP) begin
            if (rd_q.cluster) begin
              cbase_q <= rd_q.ts;
            end
            head_q <= head_q + AddrOne;
            count_q <= count_q - CntOne;
            aud_q <= aud_q - tofq_pkg::CntW'(rd_q.track);
          end
          out_vld_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Queue flags follow the settled count while the result beat waits
  always_comb begin
    out_beat = res_q;
    out_beat.queue_empty = (count_q == '0);
    out_beat.video_pending = (count_q != aud_q);
    out_beat.audio_pending = (aud_q != '0);
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = out_beat;

  `TOFQ_ASSERT_NOW(a_count_range, 1'b1, count_q <= FullCnt, "pending count beyond depth")
  `TOFQ_ASSERT_NOW(a_audio_le_count, 1'b1, aud_q <= count_q, "audio count above pending")
  `TOFQ_ASSERT_NOW(a_busy_no_result, state_q != S_IDLE, !out_vld_q, "result while busy")
  `TOFQ_ASSERT_NEXT(a_write_grows, state_q == S_WR, count_q == $past(count_q) + CntOne,
    "add did not grow queue")

endmodule
